### sv/mns_pkg.sv
// Shared types and constants for the mean neighbour select block.
// Holds the beat formats of both channels and the sentinel values; no dependencies.
`default_nettype none

package mns_pkg;

   // Sentinels returned when no stored value lies on one side of the mean.
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

   // Number of fraction bits of the reported mean.
   localparam int unsigned MEAN_FRAC_W = 8;
   localparam int unsigned MEAN_W      = 40;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0]        below_max;
      logic signed [31:0]        above_min;
      logic signed [MEAN_W-1:0]  mean_fixed;
      logic                      overflow;
   } rsp_type;

endpackage

`default_nettype wire

### sv/mns_front.sv
// Front end of the mean neighbour select block: accepts value beats, stores them
// in a two-bank value memory and keeps the running count and sum of the open set.
// Depends on mns_pkg.
`default_nettype none

module mns_front #(
   parameter int unsigned MAX_ITEMS = 1024,
   localparam int unsigned AW    = $clog2(MAX_ITEMS),
   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1),
   localparam int unsigned SUM_W = AW + 32,
   localparam int unsigned JOB_W = CNT_W + SUM_W + 2
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_push,
   input  wire mns_pkg::req_type         req_data,
   output logic                          req_full,
   output logic                          job_push,
   output logic [JOB_W-1:0]              job_data,
   input  wire                           job_full,
   input  wire                           rd_en,
   input  wire [AW:0]                    rd_addr,
   output logic signed [31:0]            rd_data
);

   localparam int unsigned DEPTH = 2 ** (AW + 1);

   typedef struct packed {
      logic                    bank;
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
      logic                    overflow;
   } job_type;

   logic                    bank_ff, bank_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_cur;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_cur;
   logic                    ovf_ff, ovf_in, ovf_cur;
   logic                    accept, has_room, store;
   logic signed [SUM_W-1:0] value_ext;
   job_type                 job;

   logic signed [31:0]      store_mem [DEPTH];
   logic signed [31:0]      rd_data_ff;

   always_comb begin
      accept    = req_push && !job_full;
      has_room  = cnt_ff < CNT_W'(MAX_ITEMS);
      store     = accept && has_room;
      value_ext = {{(SUM_W-32){req_data.value[31]}}, req_data.value};
      cnt_cur   = store ? cnt_ff + 1'b1 : cnt_ff;
      sum_cur   = store ? sum_ff + value_ext : sum_ff;
      ovf_cur   = ovf_ff || (accept && !has_room);

      job.bank     = bank_ff;
      job.count    = cnt_cur;
      job.sum      = sum_cur;
      job.overflow = ovf_cur;
      job_data     = job;
      job_push     = accept && req_data.last;
      req_full     = job_full;

      bank_in = bank_ff;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      ovf_in  = ovf_ff;
      if (job_push) begin
         // The set is closed: start the next one in the other bank.
         bank_in = !bank_ff;
         cnt_in  = '0;
         sum_in  = '0;
         ovf_in  = 1'b0;
      end else if (accept) begin
         cnt_in = cnt_cur;
         sum_in = sum_cur;
         ovf_in = ovf_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         bank_ff <= bank_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         store_mem[{bank_ff, cnt_ff[AW-1:0]}] <= req_data.value;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/mns_job_queue.sv
// Two-entry queue of closed sets between the front end and the back end.
// An entry stays at the head until the back end has finished with it; no dependencies.
`default_nettype none

module mns_job_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire [WIDTH-1:0]   din,
   output logic              full,
   input  wire               pop,
   output logic [WIDTH-1:0]  dout,
   output logic              empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = cnt_ff == 2'd2;
      empty   = cnt_ff == 2'd0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      dout    = entry_ff[rptr_ff];
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

### sv/mns_div.sv
// Radix-2 restoring divider for the scaled mean, one quotient bit per cycle.
// Divides (dividend * 256) by an unsigned divisor, truncating toward zero. Uses mns_pkg.
`default_nettype none

module mns_div #(
   parameter int unsigned DIVIDEND_W = 42,
   parameter int unsigned DIVISOR_W  = 11
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire signed [DIVIDEND_W-1:0]        dividend,
   input  wire [DIVISOR_W-1:0]                divisor,
   output logic                               done,
   output logic signed [mns_pkg::MEAN_W-1:0]  quotient
);

   localparam int unsigned QW     = DIVIDEND_W + mns_pkg::MEAN_FRAC_W;
   localparam int unsigned STEP_W = $clog2(QW + 1);

   logic [QW-1:0]          quo_ff, quo_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   div_ff;
   logic                   neg_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   busy_ff, done_ff;
   logic [DIVISOR_W:0]     trial, diff;
   logic                   ge;
   logic [DIVIDEND_W-1:0]  mag;
   logic [QW:0]            signed_q;

   always_comb begin
      mag    = dividend[DIVIDEND_W-1] ? ~dividend + 1'b1 : dividend;
      trial  = {rem_ff, quo_ff[QW-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[QW-2:0], ge};
      signed_q = neg_ff ? ~{1'b0, quo_ff} + 1'b1 : {1'b0, quo_ff};
      quotient = signed_q[mns_pkg::MEAN_W-1:0];
      done     = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= STEP_W'(QW);
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {mag, {mns_pkg::MEAN_FRAC_W{1'b0}}};
         rem_ff <= '0;
         div_ff <= divisor;
         neg_ff <= dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

### sv/mns_back.sv
// Back end of the mean neighbour select block: scans a closed set through a
// three-stage read/multiply/compare pipeline, runs the mean divider and holds the result.
// Depends on mns_pkg and mns_div.
`default_nettype none

module mns_back #(
   parameter int unsigned MAX_ITEMS = 1024,
   localparam int unsigned AW     = $clog2(MAX_ITEMS),
   localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1),
   localparam int unsigned SUM_W  = AW + 32,
   localparam int unsigned JOB_W  = CNT_W + SUM_W + 2
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      job_empty,
   input  wire [JOB_W-1:0]          job_data,
   output logic                     job_pop,
   output logic                     rd_en,
   output logic [AW:0]              rd_addr,
   input  wire signed [31:0]        rd_data,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output mns_pkg::rsp_type         rsp_data
);

   localparam int unsigned PROD_W = 32 + CNT_W + 1;

   typedef struct packed {
      logic                    bank;
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
      logic                    overflow;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   job_type                  job_ff, job_head;
   logic [CNT_W-1:0]         idx_ff;
   logic                     v1_ff, v2_ff;
   logic signed [31:0]       x_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in, sum_ext;
   logic signed [31:0]       below_ff, above_ff;
   logic                     out_valid_ff;
   mns_pkg::rsp_type         out_ff, result;
   logic                     start, finish, issue, scan_done;
   logic                     div_done;
   logic signed [mns_pkg::MEAN_W-1:0] div_q;

   assign job_head = job_type'(job_data);

   mns_div #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W (CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .dividend(job_head.sum),
      .divisor (job_head.count),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      start   = (state_ff == ST_RUN) ? 1'b0 : !job_empty;
      issue   = (state_ff == ST_RUN) && (idx_ff < job_ff.count);
      rd_en   = issue;
      rd_addr = {job_ff.bank, idx_ff[AW-1:0]};
      prod_in = PROD_W'(rd_data) * PROD_W'($signed({1'b0, job_ff.count}));
      sum_ext = {{(PROD_W-SUM_W){job_ff.sum[SUM_W-1]}}, job_ff.sum};
      scan_done = !issue && !v1_ff && !v2_ff;
      finish  = (state_ff == ST_RUN) && scan_done && div_done
                && (!out_valid_ff || rsp_pop);
      job_pop = finish;

      result.below_max  = below_ff;
      result.above_min  = above_ff;
      result.mean_fixed = (job_ff.count == '0) ? '0 : div_q;
      result.overflow   = job_ff.overflow;

      rsp_empty = !out_valid_ff;
      rsp_data  = out_ff;

      case (state_ff)
         ST_IDLE: begin
            state_in = start ? ST_RUN : ST_IDLE;
         end
         ST_RUN: begin
            state_in = finish ? ST_IDLE : ST_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         job_ff   <= job_head;
         idx_ff   <= '0;
         below_ff <= mns_pkg::INT_MIN;
         above_ff <= mns_pkg::INT_MAX;
      end else begin
         if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         // Values equal to the mean match neither side.
         if (v2_ff && (prod_ff < sum_ext) && (x_ff > below_ff)) begin
            below_ff <= x_ff;
         end
         if (v2_ff && (prod_ff > sum_ext) && (x_ff < above_ff)) begin
            above_ff <= x_ff;
         end
      end
      if (v1_ff) begin
         x_ff    <= rd_data;
         prod_ff <= prod_in;
      end
      if (finish) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire

### sv/mean_neighbour_select.sv
// Input beats are taken at one per cycle while the two-entry set queue has room.
// The back end's scan (one stored value per cycle) and the bit-serial mean divider
// bound the per-set time; loading of the next set overlaps both.
// Reset is synchronous and active high; it clears control state, not the value memory.
`default_nettype none

module mean_neighbour_select #(
   parameter int unsigned MAX_ITEMS = 1024
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   input  wire mns_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output mns_pkg::rsp_type   rsp_data
);

   localparam int unsigned AW    = $clog2(MAX_ITEMS);
   localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int unsigned SUM_W = AW + 32;
   localparam int unsigned JOB_W = CNT_W + SUM_W + 2;

   // A closed set travels from the front end to the back end as one descriptor:
   // its memory bank, value count, exact sum and the dropped-value flag.
   logic               job_push, job_full, job_pop, job_empty;
   logic [JOB_W-1:0]   job_in, job_out;

   // Read port of the value memory, driven by the back end's scan.
   logic               rd_en;
   logic [AW:0]        rd_addr;
   logic signed [31:0] rd_data;

   // The front end writes each beat into the bank of the open set and keeps the
   // running sum. Values past MAX_ITEMS are dropped and only flagged. The memory
   // has two banks, so a new set loads while the back end scans the previous one;
   // the front end stalls only when both banks hold closed sets.
   mns_front #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // The head entry is released only when its result is registered, so a bank is
   // never overwritten while it is being scanned.
   mns_job_queue #(
      .WIDTH(JOB_W)
   ) u_job_queue (
      .clock(clock),
      .reset(reset),
      .push (job_push),
      .din  (job_in),
      .full (job_full),
      .pop  (job_pop),
      .dout (job_out),
      .empty(job_empty)
   );

   // The back end compares every stored value v against the mean exactly, as
   // v * count against sum, so no fraction is rounded. The scaled mean comes from
   // a divider that runs alongside the scan. The result sits in an output register
   // until it is popped.
   mns_back #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(job_empty),
      .job_data (job_out),
      .job_pop  (job_pop),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### sv/mns_checker.sv
// Port-level checks for the mean neighbour select block, bound to its top level.
// Depends on mns_pkg and mean_neighbour_select.
`default_nettype none

module mns_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_full,
   input wire               rsp_empty,
   input wire               rsp_pop,
   input wire mns_pkg::rsp_type rsp_data
);

   // Reset leaves no result waiting.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   // Reset frees both memory banks, so input is taken at once.
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input stalled after reset");

   // A waiting result that is not popped stays.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result dropped without a pop");

   // A waiting result that is not popped keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("result changed while waiting");

endmodule

bind mean_neighbour_select mns_checker u_mns_checker (
   .clock    (clock),
   .reset    (reset),
   .req_full (req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data)
);

`default_nettype wire
